>>> src/ktc_pkg.sv
// ktc_pkg: shared types and constants for the keyed table with compaction
// holds stream widths, action and status codes, fsm states and the
// controller/datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package ktc_pkg;

    // default sizing for the top level parameters
    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // fixed field widths
    localparam int ACT_W    = 2;
    localparam int KEY_W    = 32;
    localparam int PAY_IN_W = 32;
    localparam int POS_W    = 6;
    localparam int STS_W    = 3;
    localparam int CNT_O_W  = 7;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_READ   = 2'd3
    } act_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK           = 3'd0,
        ST_DUPLICATE    = 3'd1,
        ST_EMPTY        = 3'd2,
        ST_NOT_FOUND    = 3'd3,
        ST_FULL         = 3'd4,
        ST_BAD_POSITION = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RDWAIT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // latch the incoming transfer
        logic scan;    // key search over stored entries
        logic shift;   // compaction after a delete
        logic rd_pos;  // read entry at the requested position
        logic finish;  // commit and load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;       // key compare matched this cycle
        logic drained;   // no read in flight and pointer at the count
        logic is_del;    // latched action is a delete
        logic out_free;  // result register can take a new result
    } dp_stat_t;

endpackage

>>> src/ktc_ctrl.sv
// ktc_ctrl: sequencing state machine for the keyed table
// steps each item through the scan, shift, read and result phases its action needs
// depends on ktc_pkg
`timescale 1ns / 1ps

module ktc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  ktc_pkg::act_t       s_action,
    input  ktc_pkg::dp_stat_t   stat,
    output logic                s_tready,
    output ktc_pkg::ctrl_cmd_t  cmd
);
    import ktc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_action == ACT_READ) ? S_RDWAIT : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit) begin
                    state_next = stat.is_del ? S_SHIFT : S_DONE;
                end else if (stat.drained) begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.drained) begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT: begin
                cmd.rd_pos = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/ktc_datapath.sv
// ktc_datapath: key and payload memories, entry count, scan pointer and
// result register for the keyed table; driven by ktc_ctrl commands
// depends on ktc_pkg
`timescale 1ns / 1ps

module ktc_datapath #(
    parameter int TABLE_DEPTH  = ktc_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ktc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ktc_pkg::ctrl_cmd_t            cmd,
    input  logic [ktc_pkg::ACT_W-1:0]     s_tuser,
    input  logic [ktc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tready,
    output ktc_pkg::dp_stat_t             stat,
    output logic                          m_tvalid,
    output logic [ktc_pkg::STS_W-1:0]     m_tuser,
    output logic [ktc_pkg::M_TDATA_W-1:0] m_tdata
);
    import ktc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PC_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // storage, contents undefined until written
    logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

    // latched item
    act_t                    act_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [POS_W-1:0]        pos_reg;

    // control state
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        ptr_reg;
    logic                    rd_vld_reg;
    logic                    found_reg;
    logic                    out_vld_reg;

    // index bookkeeping and read data
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [KEY_W-1:0]        key_q_reg;
    logic [PAYLOAD_BITS-1:0] pay_q_reg;

    // result register
    status_t                 sts_reg;
    logic [CNT_O_W-1:0]      cnt_o_reg;
    logic [KEY_W-1:0]        okey_reg;
    logic [PAY_IN_W-1:0]     opay_reg;

    logic                    hit;
    logic                    ptr_lt_cnt;
    logic                    issue;
    logic                    rd_en;
    logic [IDX_W-1:0]        raddr;
    logic                    we_key;
    logic                    we_pay;
    logic [IDX_W-1:0]        waddr;
    logic [KEY_W-1:0]        wkey;
    logic [PAYLOAD_BITS-1:0] wpay;
    logic                    full;
    logic                    empty;
    logic                    pos_bad;
    status_t                 res_sts;
    logic [CNT_W-1:0]        count_next;
    logic [KEY_W-1:0]        res_key;
    logic [PAY_IN_W-1:0]     res_pay;
    logic                    commit_add;
    logic                    commit_upd;

    // scan / shift read pipeline
    assign hit        = rd_vld_reg && (key_q_reg == key_reg);
    assign ptr_lt_cnt = ptr_reg < count_reg;
    assign issue      = ((cmd.scan && !hit) || cmd.shift) && ptr_lt_cnt;
    assign rd_en      = issue || cmd.rd_pos;
    assign raddr      = cmd.rd_pos ? IDX_W'(pos_reg) : ptr_reg[IDX_W-1:0];

    assign full    = count_reg == CNT_W'(TABLE_DEPTH);
    assign empty   = count_reg == '0;
    assign pos_bad = PC_W'(pos_reg) >= PC_W'(count_reg);

    // result and commit decisions
    always_comb begin
        res_sts    = ST_OK;
        count_next = count_reg;
        res_key    = '0;
        res_pay    = '0;
        commit_add = 1'b0;
        commit_upd = 1'b0;
        case (act_reg)
            ACT_ADD: begin
                if (full) begin
                    res_sts = ST_FULL;
                end else if (found_reg) begin
                    res_sts = ST_DUPLICATE;
                end else begin
                    commit_add = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (empty) begin
                    res_sts = ST_EMPTY;
                end else if (!found_reg) begin
                    res_sts = ST_NOT_FOUND;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_UPDATE: begin
                if (empty) begin
                    res_sts = ST_EMPTY;
                end else if (!found_reg) begin
                    res_sts = ST_NOT_FOUND;
                end else begin
                    commit_upd = 1'b1;
                end
            end
            ACT_READ: begin
                if (pos_bad) begin
                    res_sts = ST_BAD_POSITION;
                end else begin
                    res_key = key_q_reg;
                    res_pay = PAY_IN_W'(pay_q_reg);
                end
            end
            default: begin
                res_sts = ST_OK;
            end
        endcase
    end

    // single write port: shift moves entry down, commit appends or updates
    always_comb begin
        we_key = 1'b0;
        we_pay = 1'b0;
        waddr  = rd_idx_reg - IDX_W'(1);
        wkey   = key_q_reg;
        wpay   = pay_q_reg;
        if (cmd.shift && rd_vld_reg) begin
            we_key = 1'b1;
            we_pay = 1'b1;
        end else if (cmd.finish && commit_add) begin
            we_key = 1'b1;
            we_pay = 1'b1;
            waddr  = count_reg[IDX_W-1:0];
            wkey   = key_reg;
            wpay   = pay_reg;
        end else if (cmd.finish && commit_upd) begin
            we_pay = 1'b1;
            waddr  = hit_idx_reg;
            wpay   = pay_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_key) begin
            key_mem[waddr] <= wkey;
        end
        if (rd_en) begin
            key_q_reg <= key_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_pay) begin
            pay_mem[waddr] <= wpay;
        end
        if (rd_en) begin
            pay_q_reg <= pay_mem[raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end else begin
                rd_vld_reg <= issue;
                if (cmd.scan && hit) begin
                    found_reg <= 1'b1;
                    ptr_reg   <= CNT_W'(rd_idx_reg) + CNT_W'(1);
                end else if (issue) begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
            end
            if (cmd.finish) begin
                count_reg   <= count_next;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= act_t'(s_tuser);
            key_reg <= s_tdata[31:0];
            pay_reg <= PAYLOAD_BITS'(s_tdata[63:32]);
            pos_reg <= s_tdata[69:64];
        end
        if (issue) begin
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.scan && hit) begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmd.finish) begin
            sts_reg   <= res_sts;
            cnt_o_reg <= CNT_O_W'(count_next);
            okey_reg  <= res_key;
            opay_reg  <= res_pay;
        end
    end

    assign stat.hit      = hit;
    assign stat.drained  = !rd_vld_reg && !ptr_lt_cnt;
    assign stat.is_del   = act_reg == ACT_DELETE;
    assign stat.out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = sts_reg;
    assign m_tdata  = {1'b0, opay_reg, okey_reg, cnt_o_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_only_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !cmd.finish |=> $stable(count_reg))
        else $error("entry count changed outside result commit");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift && rd_vld_reg |-> (CNT_W'(rd_idx_reg) < count_reg) && (rd_idx_reg != '0))
        else $error("compaction move outside stored entries");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan && hit |-> CNT_W'(rd_idx_reg) < count_reg)
        else $error("key match beyond entry count");
`endif

endmodule

>>> src/keyed_table_with_compaction_unit.sv
// keyed_table_with_compaction_unit: top level of the keyed table
// joins the ktc_ctrl state machine and the ktc_datapath storage
// depends on ktc_pkg, ktc_ctrl, ktc_datapath
`timescale 1ns / 1ps

//  channel  | direction | tuser            | tdata (lowest bit up)
//  ---------+-----------+------------------+------------------------------------------
//  s_       | in        | action [1:0]     | entry_key, entry_payload, read_position
//  m_       | out       | status [2:0]     | count_after, out_key, out_payload
//
// one item in flight at a time; s_tready is high only between items
// the next input transfer can follow in the cycle after the result register
// is loaded; a read goes through the positional read of both memories; add
// and update go through the one-entry-per-cycle key scan over the key memory
// with its registered read; delete goes through the scan up to the match, then
// one compaction move per later entry through the single write port
// reset is synchronous and active low; it clears the count, the memories hold
// stale data that is never read below the count
// a stalled result waits in the output register while the next item is taken in

module keyed_table_with_compaction_unit #(
    parameter int TABLE_DEPTH  = ktc_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ktc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item transfer
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ktc_pkg::ACT_W-1:0]     s_tuser,   // action
    input  logic [ktc_pkg::S_TDATA_W-1:0] s_tdata,   // entry_key, entry_payload,
                                                     // read_position, zero pad
    // result transfer
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ktc_pkg::STS_W-1:0]     m_tuser,   // status
    output logic [ktc_pkg::M_TDATA_W-1:0] m_tdata    // count_after, out_key,
                                                     // out_payload, zero pad
);
    import ktc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencing: idle, key scan, compaction, positional read, result hand-off
    ktc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (act_t'(s_tuser)),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // memories, count, scan pointer and result register
    ktc_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule
